@@ rtl/lidar_scan_min_range_binning_macros.svh @@
// Assertion helpers for the lidar binning block.
`ifndef LIDAR_SCAN_MIN_RANGE_BINNING_MACROS_SVH
`define LIDAR_SCAN_MIN_RANGE_BINNING_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define LSMRB_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("lsmrb assertion failed");
// Next-cycle implication.
`define LSMRB_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("lsmrb assertion failed");
`else
`define LSMRB_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define LSMRB_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

@@ rtl/lsmrb_pkg.sv @@
package lsmrb_pkg;

	localparam int NUM_BINS    = 1024;
	localparam int MAX_SAMPLES = 4096;
	localparam int RANGE_BITS  = 24;

	localparam int REQ_W     = 2;
	localparam int INDEX_W   = 12;
	localparam int IN_RANGE_W = 24;
	localparam int SEL_W     = 10;
	localparam int OUT_BIN_W = 10;
	localparam int OUT_RANGE_W = 24;
	localparam int VBINS_W   = 11;
	localparam int SSEEN_W   = 13;

	localparam int START_W   = 20;
	localparam int STEP_W    = 19;
	localparam int CFG_W     = 24;
	localparam int CFG_IDX_W = 3;

	localparam logic [START_W-1:0] START_RST = START_W'(0);
	localparam logic [STEP_W-1:0]  STEP_RST  = STEP_W'(512);
	localparam logic [CFG_W-1:0]   MINR_RST  = CFG_W'(10);
	localparam logic [CFG_W-1:0]   RLOW_RST  = CFG_W'(921600);
	localparam logic [CFG_W-1:0]   RHIGH_RST = CFG_W'(1126400);

	localparam int FULL_TURN   = 368640;
	localparam int TURN_SHIFT  = 13;
	localparam int TURN_ODD    = FULL_TURN >> TURN_SHIFT;
	localparam int TURN_OFFSET = 2 * FULL_TURN;
	localparam int PROD_W      = STEP_W + INDEX_W;
	localparam int ANGLE_W     = 32;
	localparam int HI_W        = ANGLE_W - TURN_SHIFT;
	localparam int RECIP       = (1 << HI_W) / TURN_ODD;
	localparam int QW          = $clog2(RECIP + 1);
	localparam int RW          = $clog2(TURN_ODD);
	localparam int MW          = RW + TURN_SHIFT;

	localparam int BIN_W    = $clog2(NUM_BINS);
	localparam int ROW_BINS = 4;
	localparam int LANE_W   = $clog2(ROW_BINS);
	localparam int NUM_ROWS = NUM_BINS / ROW_BINS;
	localparam int ROW_W    = $clog2(NUM_ROWS);
	localparam int SCNT_W   = $clog2(MAX_SAMPLES + 1);
	localparam int OCNT_W   = $clog2(NUM_BINS + 1);

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [REQ_W-1:0] {
		REQ_CLEAR  = 2'd0,
		REQ_SAMPLE = 2'd1,
		REQ_READ   = 2'd2
	} req_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ANGLE_START = 3'd0,
		CFG_ANGLE_STEP  = 3'd1,
		CFG_MIN_RANGE   = 3'd2,
		CFG_REJECT_LOW  = 3'd3,
		CFG_REJECT_HIGH = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic [REQ_W-1:0]      req_type;
		logic                  ok;
		logic [BIN_W-1:0]      bin;
		logic [SEL_W-1:0]      sel;
		logic [RANGE_BITS-1:0] smp_range;
	} q_item_t;

	typedef struct packed {
		logic                  occ;
		logic [RANGE_BITS-1:0] min_range;
	} lane_t;

	typedef lane_t [ROW_BINS-1:0] row_t;

endpackage

@@ rtl/lsmrb_if.sv @@
interface lsmrb_req_if;
	logic                               valid;
	logic                               ready;
	logic [lsmrb_pkg::REQ_W-1:0]        req_type;
	logic [lsmrb_pkg::INDEX_W-1:0]      sample_index;
	logic [lsmrb_pkg::IN_RANGE_W-1:0]   sample_range;
	logic [lsmrb_pkg::SEL_W-1:0]        bin_select;

	modport source (output valid, req_type, sample_index, sample_range, bin_select,
		input ready);
	modport sink (input valid, req_type, sample_index, sample_range, bin_select,
		output ready);
endinterface

interface lsmrb_rsp_if;
	logic                               valid;
	logic                               ready;
	logic                               accepted;
	logic [lsmrb_pkg::OUT_BIN_W-1:0]    sample_bin;
	logic                               bin_valid;
	logic [lsmrb_pkg::OUT_RANGE_W-1:0]  bin_range;
	logic [lsmrb_pkg::VBINS_W-1:0]      valid_bins;
	logic [lsmrb_pkg::SSEEN_W-1:0]      samples_seen;

	modport source (output valid, accepted, sample_bin, bin_valid, bin_range, valid_bins,
		samples_seen, input ready);
	modport sink (input valid, accepted, sample_bin, bin_valid, bin_range, valid_bins,
		samples_seen, output ready);
endinterface

@@ rtl/lsmrb_ram.sv @@
module lsmrb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

@@ rtl/lsmrb_front.sv @@
module lsmrb_front (
	input  logic                              clk,
	input  logic                              arst_n,
	lsmrb_req_if.sink                         req,
	input  logic                              cfg_wr_en,
	input  logic [lsmrb_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [lsmrb_pkg::CFG_W-1:0]       cfg_wdata,
	output logic                              push_valid,
	input  logic                              push_ready,
	output lsmrb_pkg::q_item_t                push_item
);

	function automatic logic [lsmrb_pkg::QW-1:0] div_est(input logic [lsmrb_pkg::HI_W-1:0] x);
		logic [lsmrb_pkg::HI_W+lsmrb_pkg::QW-1:0] p;
		p = (lsmrb_pkg::HI_W + lsmrb_pkg::QW)'(x) *
			(lsmrb_pkg::HI_W + lsmrb_pkg::QW)'(lsmrb_pkg::RECIP);
		return p[lsmrb_pkg::HI_W+lsmrb_pkg::QW-1:lsmrb_pkg::HI_W];
	endfunction

	logic [lsmrb_pkg::START_W-1:0] start_q;
	logic [lsmrb_pkg::STEP_W-1:0]  step_q;
	logic [lsmrb_pkg::CFG_W-1:0]   minr_q;
	logic [lsmrb_pkg::CFG_W-1:0]   rlow_q;
	logic [lsmrb_pkg::CFG_W-1:0]   rhigh_q;

	logic stall;
	logic take;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	lsmrb_pkg::q_item_t item_in, item_s1, item_s2, item_s3, item_s4, item_s5, item_s6;

	logic [lsmrb_pkg::INDEX_W-1:0]    idx_s1;
	logic [lsmrb_pkg::PROD_W-1:0]     prod_s2;
	logic [lsmrb_pkg::HI_W-1:0]       hi_s3;
	logic [lsmrb_pkg::TURN_SHIFT-1:0] lo_s3;
	logic [lsmrb_pkg::QW-1:0]         q_s3;
	logic [lsmrb_pkg::MW-1:0]         m_s4;
	logic [lsmrb_pkg::HI_W-1:0]       x2_s5;
	logic [lsmrb_pkg::HI_W-1:0]       x2_s6;
	logic [lsmrb_pkg::QW-1:0]         q2_s6;

	logic [lsmrb_pkg::CFG_W-1:0]   rng_in;
	logic [lsmrb_pkg::ANGLE_W-1:0] start_ext;
	logic [lsmrb_pkg::ANGLE_W-1:0] angle_u;
	logic [lsmrb_pkg::HI_W-1:0]    r3;
	logic [lsmrb_pkg::HI_W-1:0]    r3c;
	logic [lsmrb_pkg::ANGLE_W-1:0] p4;
	logic [lsmrb_pkg::HI_W-1:0]    r6;
	logic [lsmrb_pkg::QW-1:0]      qc6;
	logic [lsmrb_pkg::BIN_W-1:0]   bin_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= lsmrb_pkg::START_RST;
			step_q  <= lsmrb_pkg::STEP_RST;
			minr_q  <= lsmrb_pkg::MINR_RST;
			rlow_q  <= lsmrb_pkg::RLOW_RST;
			rhigh_q <= lsmrb_pkg::RHIGH_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				lsmrb_pkg::CFG_ANGLE_START: start_q <= cfg_wdata[lsmrb_pkg::START_W-1:0];
				lsmrb_pkg::CFG_ANGLE_STEP:  step_q  <= cfg_wdata[lsmrb_pkg::STEP_W-1:0];
				lsmrb_pkg::CFG_MIN_RANGE:   minr_q  <= cfg_wdata;
				lsmrb_pkg::CFG_REJECT_LOW:  rlow_q  <= cfg_wdata;
				lsmrb_pkg::CFG_REJECT_HIGH: rhigh_q <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	assign stall     = v_s6 && !push_ready;
	assign req.ready = !stall;
	assign take      = req.valid && !stall;

	// classify the range at entry
	always_comb begin
		rng_in             = lsmrb_pkg::CFG_W'(req.sample_range[lsmrb_pkg::RANGE_BITS-1:0]);
		item_in.req_type   = req.req_type;
		item_in.ok         = (rng_in > minr_q) && !((rng_in > rlow_q) && (rng_in < rhigh_q));
		item_in.bin        = '0;
		item_in.sel        = req.bin_select;
		item_in.smp_range  = req.sample_range[lsmrb_pkg::RANGE_BITS-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (!stall) begin
			v_s1 <= take;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	always_comb begin
		start_ext = {{(lsmrb_pkg::ANGLE_W - lsmrb_pkg::START_W){start_q[lsmrb_pkg::START_W-1]}},
			start_q};
		angle_u = lsmrb_pkg::ANGLE_W'(prod_s2) + start_ext +
			lsmrb_pkg::ANGLE_W'(lsmrb_pkg::TURN_OFFSET);
		r3  = hi_s3 - lsmrb_pkg::HI_W'(q_s3) * lsmrb_pkg::HI_W'(lsmrb_pkg::TURN_ODD);
		r3c = (r3 >= lsmrb_pkg::HI_W'(lsmrb_pkg::TURN_ODD)) ?
			r3 - lsmrb_pkg::HI_W'(lsmrb_pkg::TURN_ODD) : r3;
		p4  = lsmrb_pkg::ANGLE_W'(m_s4) * lsmrb_pkg::ANGLE_W'(lsmrb_pkg::NUM_BINS);
		r6  = x2_s6 - lsmrb_pkg::HI_W'(q2_s6) * lsmrb_pkg::HI_W'(lsmrb_pkg::TURN_ODD);
		qc6 = (r6 >= lsmrb_pkg::HI_W'(lsmrb_pkg::TURN_ODD)) ?
			q2_s6 + lsmrb_pkg::QW'(1) : q2_s6;
		bin_s6 = (lsmrb_pkg::ANGLE_W'(qc6) >= lsmrb_pkg::ANGLE_W'(lsmrb_pkg::NUM_BINS)) ?
			lsmrb_pkg::BIN_W'(lsmrb_pkg::NUM_BINS - 1) : qc6[lsmrb_pkg::BIN_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (!stall) begin
			item_s1 <= item_in;
			idx_s1  <= req.sample_index;
			item_s2 <= item_s1;
			prod_s2 <= lsmrb_pkg::PROD_W'(step_q) * lsmrb_pkg::PROD_W'(idx_s1);
			item_s3 <= item_s2;
			hi_s3   <= angle_u[lsmrb_pkg::ANGLE_W-1:lsmrb_pkg::TURN_SHIFT];
			lo_s3   <= angle_u[lsmrb_pkg::TURN_SHIFT-1:0];
			q_s3    <= div_est(angle_u[lsmrb_pkg::ANGLE_W-1:lsmrb_pkg::TURN_SHIFT]);
			item_s4 <= item_s3;
			m_s4    <= {r3c[lsmrb_pkg::RW-1:0], lo_s3};
			item_s5 <= item_s4;
			x2_s5   <= p4[lsmrb_pkg::ANGLE_W-1:lsmrb_pkg::TURN_SHIFT];
			item_s6 <= item_s5;
			x2_s6   <= x2_s5;
			q2_s6   <= div_est(x2_s5);
		end
	end

	assign push_valid = v_s6;

	always_comb begin
		push_item     = item_s6;
		push_item.bin = bin_s6;
	end

endmodule

@@ rtl/lsmrb_queue.sv @@
module lsmrb_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push_valid,
	output logic               push_ready,
	input  lsmrb_pkg::q_item_t push_item,
	output logic               pop_valid,
	input  logic               pop_ready,
	output lsmrb_pkg::q_item_t pop_item
);

	lsmrb_pkg::q_item_t slot_q [lsmrb_pkg::QUEUE_DEPTH];
	logic [lsmrb_pkg::QPTR_W-1:0] wr_ptr_q;
	logic [lsmrb_pkg::QPTR_W-1:0] rd_ptr_q;
	logic [lsmrb_pkg::QCNT_W-1:0] cnt_q;
	logic push, pop;

	assign push_ready = cnt_q < lsmrb_pkg::QCNT_W'(lsmrb_pkg::QUEUE_DEPTH);
	assign pop_valid  = cnt_q != '0;
	assign pop_item   = slot_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == lsmrb_pkg::QPTR_W'(lsmrb_pkg::QUEUE_DEPTH - 1)) ?
					'0 : wr_ptr_q + lsmrb_pkg::QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == lsmrb_pkg::QPTR_W'(lsmrb_pkg::QUEUE_DEPTH - 1)) ?
					'0 : rd_ptr_q + lsmrb_pkg::QPTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + lsmrb_pkg::QCNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - lsmrb_pkg::QCNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

@@ rtl/lsmrb_back.sv @@
module lsmrb_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               pop_valid,
	output logic               pop_ready,
	input  lsmrb_pkg::q_item_t pop_item,
	lsmrb_rsp_if.source        rsp
);

	typedef enum logic {
		B_IDLE,
		B_EXEC
	} state_t;

	state_t state_q;
	lsmrb_pkg::q_item_t item_q;
	logic [lsmrb_pkg::BIN_W-1:0]  tgt_q;
	logic [lsmrb_pkg::SCNT_W-1:0] scnt_q;
	logic [lsmrb_pkg::OCNT_W-1:0] ocnt_q;
	logic [lsmrb_pkg::NUM_ROWS-1:0] row_valid_q;

	logic                         pop;
	logic [lsmrb_pkg::BIN_W-1:0]  pop_tgt;
	lsmrb_pkg::row_t              row_rd;
	lsmrb_pkg::row_t              row_wr;
	logic [lsmrb_pkg::ROW_W-1:0]  row_idx;
	logic [lsmrb_pkg::LANE_W-1:0] lane_idx;
	logic                         rowv;
	logic                         occ_old;
	logic [lsmrb_pkg::RANGE_BITS-1:0] min_old;
	logic                         upd;
	logic                         new_occ;
	logic [lsmrb_pkg::RANGE_BITS-1:0] new_min;
	logic                         fire;
	logic                         wr_en;
	logic                         in_tbl;
	logic [lsmrb_pkg::SCNT_W-1:0] scnt_n;
	logic [lsmrb_pkg::OCNT_W-1:0] ocnt_n;
	logic                         res_acc;
	logic [lsmrb_pkg::BIN_W-1:0]  res_bin;
	logic                         res_bv;
	logic [lsmrb_pkg::RANGE_BITS-1:0] res_br;

	assign pop_ready = (state_q == B_IDLE);
	assign pop       = pop_valid && pop_ready;
	assign pop_tgt   = (pop_item.req_type == lsmrb_pkg::REQ_READ) ?
		lsmrb_pkg::BIN_W'(pop_item.sel) : pop_item.bin;

	lsmrb_ram #(
		.WIDTH($bits(lsmrb_pkg::row_t)),
		.DEPTH(lsmrb_pkg::NUM_ROWS)
	) u_bin_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(row_idx),
		.wr_data(row_wr),
		.rd_en  (pop),
		.rd_addr(pop_tgt[lsmrb_pkg::BIN_W-1:lsmrb_pkg::LANE_W]),
		.rd_data(row_rd)
	);

	assign fire  = (state_q == B_EXEC) && (!rsp.valid || rsp.ready);
	assign wr_en = fire && (item_q.req_type == lsmrb_pkg::REQ_SAMPLE) && item_q.ok;

	always_comb begin
		row_idx  = tgt_q[lsmrb_pkg::BIN_W-1:lsmrb_pkg::LANE_W];
		lane_idx = tgt_q[lsmrb_pkg::LANE_W-1:0];
		rowv     = row_valid_q[row_idx];
		occ_old  = rowv && row_rd[lane_idx].occ;
		min_old  = row_rd[lane_idx].min_range;
		upd      = item_q.ok && (!occ_old || (item_q.smp_range < min_old));
		new_occ  = occ_old || item_q.ok;
		new_min  = upd ? item_q.smp_range : min_old;
		in_tbl   = 32'(item_q.sel) < 32'(lsmrb_pkg::NUM_BINS);

		for (int l = 0; l < lsmrb_pkg::ROW_BINS; l++) begin
			row_wr[l].occ       = rowv && row_rd[l].occ;
			row_wr[l].min_range = row_rd[l].min_range;
		end
		row_wr[lane_idx].occ       = 1'b1;
		row_wr[lane_idx].min_range = new_min;

		scnt_n  = scnt_q;
		ocnt_n  = ocnt_q;
		res_acc = 1'b0;
		res_bin = '0;
		res_bv  = 1'b0;
		res_br  = '0;
		unique case (item_q.req_type)
			lsmrb_pkg::REQ_CLEAR: begin
				scnt_n = '0;
				ocnt_n = '0;
			end
			lsmrb_pkg::REQ_SAMPLE: begin
				if (scnt_q < lsmrb_pkg::SCNT_W'(lsmrb_pkg::MAX_SAMPLES)) begin
					scnt_n = scnt_q + lsmrb_pkg::SCNT_W'(1);
				end
				if (item_q.ok && !occ_old) begin
					ocnt_n = ocnt_q + lsmrb_pkg::OCNT_W'(1);
				end
				res_acc = item_q.ok;
				res_bin = tgt_q;
				res_bv  = new_occ;
				res_br  = new_occ ? new_min : '0;
			end
			lsmrb_pkg::REQ_READ: begin
				res_bv = in_tbl && occ_old;
				res_br = (in_tbl && occ_old) ? min_old : '0;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q          <= B_IDLE;
			item_q           <= '0;
			tgt_q            <= '0;
			scnt_q           <= '0;
			ocnt_q           <= '0;
			row_valid_q      <= '0;
			rsp.valid        <= 1'b0;
			rsp.accepted     <= 1'b0;
			rsp.sample_bin   <= '0;
			rsp.bin_valid    <= 1'b0;
			rsp.bin_range    <= '0;
			rsp.valid_bins   <= '0;
			rsp.samples_seen <= '0;
		end else begin
			unique case (state_q)
				B_IDLE: begin
					if (pop) begin
						item_q  <= pop_item;
						tgt_q   <= pop_tgt;
						state_q <= B_EXEC;
					end
				end
				B_EXEC: begin
					if (fire) begin
						state_q <= B_IDLE;
					end
				end
				default: state_q <= B_IDLE;
			endcase

			if (fire) begin
				scnt_q <= scnt_n;
				ocnt_q <= ocnt_n;
				if (item_q.req_type == lsmrb_pkg::REQ_CLEAR) begin
					row_valid_q <= '0;
				end else if (wr_en) begin
					row_valid_q[row_idx] <= 1'b1;
				end
				rsp.valid        <= 1'b1;
				rsp.accepted     <= res_acc;
				rsp.sample_bin   <= lsmrb_pkg::OUT_BIN_W'(res_bin);
				rsp.bin_valid    <= res_bv;
				rsp.bin_range    <= lsmrb_pkg::OUT_RANGE_W'(res_br);
				rsp.valid_bins   <= lsmrb_pkg::VBINS_W'(ocnt_n);
				rsp.samples_seen <= lsmrb_pkg::SSEEN_W'(scnt_n);
			end else if (rsp.ready) begin
				rsp.valid <= 1'b0;
			end
		end
	end

endmodule

@@ rtl/lidar_scan_min_range_binning.sv @@
// Lidar scan minimum-range binning.
// req channel (valid/ready): clear (req_type 0), range sample (1) or bin read (2).
// rsp channel (valid/ready): one result per request, in request order.
// cfg port: cfg_wr_en/cfg_index/cfg_wdata write the angle and range registers;
// write only while no request is outstanding.
// A sample's angle bin is computed in a six-stage front pipeline (step times
// index, wrap modulo a full turn, scale to the bin count). A two-entry queue
// feeds the back end, which does a read-modify-write of the bin RAM.
// The back end takes a new request only after the bin RAM read-modify-write
// of the last one is done (read on the pop, update and write in B_EXEC once
// rsp is free). The front takes one transfer per cycle until the queue fills.
// A req transfer passes the six front stages, the queue and B_EXEC before rsp valid.
// Reset: all bins empty, both counters zero, registers at their defaults; the
// block is ready on the first cycle after reset, with no clearing pass.
// When rsp is stalled the result holds, the back end waits, the queue fills and
// then req.ready drops.
`include "lidar_scan_min_range_binning_macros.svh"

module lidar_scan_min_range_binning (
	input  logic                            clk,
	input  logic                            arst_n,
	lsmrb_req_if.sink                       req,
	lsmrb_rsp_if.source                     rsp,
	input  logic                            cfg_wr_en,
	input  logic [lsmrb_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [lsmrb_pkg::CFG_W-1:0]     cfg_wdata
);

	logic               push_valid, push_ready;
	logic               pop_valid, pop_ready;
	lsmrb_pkg::q_item_t push_item, pop_item;

	lsmrb_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_item (push_item)
	);

	lsmrb_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_item (push_item),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_item  (pop_item)
	);

	lsmrb_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.pop_valid(pop_valid),
		.pop_ready(pop_ready),
		.pop_item (pop_item),
		.rsp      (rsp)
	);

	`LSMRB_ASSERT_NXT(a_one_in_flight, clk, arst_n, pop_valid && pop_ready, !pop_ready)
	`LSMRB_ASSERT_IMP(a_accept_occupies, clk, arst_n, rsp.valid && rsp.accepted, rsp.bin_valid)
	`LSMRB_ASSERT_IMP(a_empty_zero, clk, arst_n, rsp.valid && !rsp.bin_valid, rsp.bin_range == '0)
	`LSMRB_ASSERT_IMP(a_bins_bound, clk, arst_n, rsp.valid, rsp.valid_bins <= lsmrb_pkg::VBINS_W'(lsmrb_pkg::NUM_BINS))

endmodule
